// File: rtl/touch_stroke_decimator_macros.svh
// Assertion helpers for touch_stroke_decimator.sv. All of them sample on the
// rising edge of clock and are switched off while reset is high.
`ifndef TOUCH_STROKE_DECIMATOR_MACROS_SVH
`define TOUCH_STROKE_DECIMATOR_MACROS_SVH

// A condition that must hold at every edge.
`define TSD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TSD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tsd_pkg.sv
`default_nettype none

package tsd_pkg;

   // History depth and fixed point format of the stored points.
   localparam int HISTORY_POINTS = 32;
   localparam int FRACTION_BITS  = 8;

   // Field widths.
   localparam int COORD_W       = 8;
   localparam int MOVE_W        = 9;
   localparam int SUM_W         = 16;
   localparam int COUNT_W       = 8;
   localparam int DIST_W        = 16;
   localparam int INDEX_OUT_W   = 5;
   localparam int TOTAL_OUT_W   = 6;

   // Derived widths.
   localparam int POINT_W    = COORD_W + FRACTION_BITS;
   localparam int DIVIDEND_W = SUM_W + FRACTION_BITS;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
   localparam int IDX_W      = $clog2(HISTORY_POINTS);
   localparam int LEN_W      = $clog2(HISTORY_POINTS + 1);
   localparam int SQ_W       = 2 * MOVE_W;

   // Stream payload layout.
   localparam int REQ_FIELDS_W = 2 * COORD_W + 2 * MOVE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + 2 * COORD_W + INDEX_OUT_W + TOTAL_OUT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // Square root: the sum of two squares of a 9-bit magnitude is at most
   // 2**17, so the digit-pair search starts at 2**16.
   localparam logic [SQ_W-1:0] ROOT_START = SQ_W'(1) << (SQ_W - 2);

   // Group divisor growth after each halving of the history.
   localparam logic [COUNT_W:0]   DIVISOR_STEP = (COUNT_W + 1)'(2);
   localparam logic [COUNT_W-1:0] DIVISOR_MAX  = '1;

   // Register file.
   localparam int                CSR_ADDR_W        = 2;
   localparam int                CSR_DATA_W        = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRE_DISTANCE = CSR_ADDR_W'(0);
   localparam logic [DIST_W-1:0] FIRE_DISTANCE_RESET = DIST_W'(88);

   // Action codes carried in the request tuser bit.
   localparam logic ACTION_PRESS   = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   // One history entry: x in the low half, y in the high half.
   typedef struct packed {
      logic [POINT_W-1:0] y;
      logic [POINT_W-1:0] x;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/touch_stroke_decimator.sv
// Channel  Direction  Handshake               Payload
// req      in         req_tvalid/req_tready   tuser: action; tdata: x, y, move x, move y
// rsp      out        rsp_tvalid/rsp_tready   tuser: point_valid; tdata: point fields;
//                                             tlast: final result of a release
// csr      in/out     APB, pready always high fire_distance at byte address 0
//
// A pressed sample runs the square root and, when it closes a group, the
// 24-step restoring divider side by side before it returns to idle or
// appends a point. A point appended to a full history first runs a halving
// sweep through the history memory, which has one read and one write port.
// A release streams each stored point through a memory read state and an
// output load state, or gives a single status result. Reset is synchronous
// and needs no clearing pass.
// The output register lets a new request transfer while a result waits.
`default_nettype none

`include "touch_stroke_decimator_macros.svh"

module touch_stroke_decimator
   import tsd_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,

   input  wire                   req_tvalid,
   output logic                  req_tready,
   // [7:0] touch_x, [15:8] touch_y, [24:16] move_x, [33:25] move_y, rest zero
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  wire                   req_tuser,

   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // [0] fired, [8:1] point_x, [16:9] point_y, [21:17] point_index,
   // [27:22] point_total, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] point_valid
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,

   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0] csr_paddr,
   input  wire  [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WORK,
      ST_HALVE,
      ST_WRITE,
      ST_REPORT,
      ST_EMIT,
      ST_LOAD
   } state_type;

   // Control and stroke state.
   state_type          state_ff;
   logic               finger_down_ff;
   logic [DIST_W-1:0]  fire_distance_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [COUNT_W-1:0] divisor_ff;
   logic [SUM_W-1:0]   sum_x_ff;
   logic [SUM_W-1:0]   sum_y_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic               trig_ff;
   logic               fired_ff;

   // Square root unit.
   logic [SQ_W-1:0]    root_v_ff;
   logic [SQ_W-1:0]    root_r_ff;
   logic [SQ_W-1:0]    root_bit_ff;

   // Divider, one quotient bit per cycle for x and y side by side.
   logic [DIVIDEND_W-1:0] quo_x_ff;
   logic [DIVIDEND_W-1:0] quo_y_ff;
   logic [COUNT_W-1:0]    rem_x_ff;
   logic [COUNT_W-1:0]    rem_y_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;

   // Halving sweep and release streaming.
   logic [LEN_W-1:0]   hv_cnt_ff;
   logic               hv_pend_ff;
   logic [IDX_W-1:0]   hv_addr_ff;
   entry_type          hv_hold_ff;
   logic [IDX_W-1:0]   emit_idx_ff;

   // History memory.
   entry_type          stroke_mem_ff [HISTORY_POINTS];
   entry_type          mem_rdata_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_fired_ff;
   logic                   rsp_point_valid_ff;
   logic [COORD_W-1:0]     rsp_x_ff;
   logic [COORD_W-1:0]     rsp_y_ff;
   logic [INDEX_OUT_W-1:0] rsp_index_ff;
   logic [TOTAL_OUT_W-1:0] rsp_total_ff;
   logic                   rsp_last_ff;

   // Request fields.
   logic                      in_action;
   logic [COORD_W-1:0]        in_x;
   logic [COORD_W-1:0]        in_y;
   logic [MOVE_W-1:0]         in_mx;
   logic [MOVE_W-1:0]         in_my;
   logic [MOVE_W-1:0]         mag_x;
   logic [MOVE_W-1:0]         mag_y;
   logic [SQ_W-1:0]           sq_x;
   logic [SQ_W-1:0]           sq_y;
   logic [SQ_W-1:0]           sq_in;

   // Values seen by a pressed sample, after the clear of a new stroke.
   logic [LEN_W-1:0]   base_len;
   logic [COUNT_W-1:0] base_divisor;
   logic [SUM_W-1:0]   base_sum_x;
   logic [SUM_W-1:0]   base_sum_y;
   logic [COUNT_W-1:0] base_count;
   logic [DIST_W-1:0]  base_dist;
   logic [SUM_W-1:0]   sum_x_in;
   logic [SUM_W-1:0]   sum_y_in;
   logic [COUNT_W-1:0] count_in;
   logic               trig_in;

   logic               req_xfer;
   logic               rsp_free;
   logic               rsp_load;
   logic               release_fired;
   logic               history_full;
   logic               emit_last;

   logic [SQ_W-1:0]    root_trial;
   logic               root_ge;
   logic [COUNT_W:0]   div_trial_x;
   logic [COUNT_W:0]   div_trial_y;
   logic [COUNT_W:0]   div_den;
   logic               div_ge_x;
   logic               div_ge_y;
   logic [COUNT_W-1:0] rem_x_in;
   logic [COUNT_W-1:0] rem_y_in;
   logic [DIST_W:0]    dist_sum;
   logic [DIST_W-1:0]  dist_in;
   logic [COUNT_W:0]   divisor_sum;
   logic [COUNT_W-1:0] divisor_in;
   logic [POINT_W:0]   avg_x_sum;
   logic [POINT_W:0]   avg_y_sum;
   entry_type          avg_entry;
   entry_type          new_entry;

   assign in_action = req_tuser;
   assign in_x      = req_tdata[0 +: COORD_W];
   assign in_y      = req_tdata[COORD_W +: COORD_W];
   assign in_mx     = req_tdata[2 * COORD_W +: MOVE_W];
   assign in_my     = req_tdata[2 * COORD_W + MOVE_W +: MOVE_W];

   // The magnitude of the most negative move still fits the unsigned width.
   assign mag_x = in_mx[MOVE_W-1] ? (~in_mx + MOVE_W'(1)) : in_mx;
   assign mag_y = in_my[MOVE_W-1] ? (~in_my + MOVE_W'(1)) : in_my;
   assign sq_x  = {{MOVE_W{1'b0}}, mag_x} * {{MOVE_W{1'b0}}, mag_x};
   assign sq_y  = {{MOVE_W{1'b0}}, mag_y} * {{MOVE_W{1'b0}}, mag_y};
   assign sq_in = sq_x + sq_y;

   // The first pressed sample after a release starts from a cleared stroke.
   assign base_len     = finger_down_ff ? len_ff     : '0;
   assign base_divisor = finger_down_ff ? divisor_ff : COUNT_W'(1);
   assign base_sum_x   = finger_down_ff ? sum_x_ff   : '0;
   assign base_sum_y   = finger_down_ff ? sum_y_ff   : '0;
   assign base_count   = finger_down_ff ? count_ff   : '0;
   assign base_dist    = finger_down_ff ? dist_ff    : '0;

   assign sum_x_in = base_sum_x + SUM_W'(in_x);
   assign sum_y_in = base_sum_y + SUM_W'(in_y);
   assign count_in = base_count + COUNT_W'(1);
   assign trig_in  = (count_in >= base_divisor) && (count_in != '0);

   assign req_tready    = (state_ff == ST_IDLE);
   assign req_xfer      = req_tvalid && req_tready;
   assign rsp_free      = !rsp_valid_ff || rsp_tready;
   // A new result enters the output register in this cycle.
   assign rsp_load      = rsp_free && (state_ff inside {ST_REPORT, ST_LOAD});
   assign release_fired = dist_ff > fire_distance_ff;
   assign history_full  = len_ff >= LEN_W'(HISTORY_POINTS);
   assign emit_last     = (LEN_W'(emit_idx_ff) + LEN_W'(1)) == len_ff;

   // One digit pair of the square root per cycle.
   assign root_trial = root_r_ff + root_bit_ff;
   assign root_ge    = root_v_ff >= root_trial;

   // One restoring division step per cycle; the remainder stays below the
   // divisor, so the shifted trial value fits one extra bit.
   assign div_den     = {1'b0, count_ff};
   assign div_trial_x = {rem_x_ff, quo_x_ff[DIVIDEND_W-1]};
   assign div_trial_y = {rem_y_ff, quo_y_ff[DIVIDEND_W-1]};
   assign div_ge_x    = div_trial_x >= div_den;
   assign div_ge_y    = div_trial_y >= div_den;
   assign rem_x_in    = div_ge_x ? COUNT_W'(div_trial_x - div_den) : div_trial_x[COUNT_W-1:0];
   assign rem_y_in    = div_ge_y ? COUNT_W'(div_trial_y - div_den) : div_trial_y[COUNT_W-1:0];

   // Saturating updates.
   assign dist_sum    = {1'b0, dist_ff} + (DIST_W + 1)'(root_r_ff);
   assign dist_in     = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
   assign divisor_sum = {1'b0, divisor_ff} + DIVISOR_STEP;
   assign divisor_in  = divisor_sum[COUNT_W] ? DIVISOR_MAX : divisor_sum[COUNT_W-1:0];

   // Pairwise average during the halving sweep.
   assign avg_x_sum   = {1'b0, hv_hold_ff.x} + {1'b0, mem_rdata_ff.x};
   assign avg_y_sum   = {1'b0, hv_hold_ff.y} + {1'b0, mem_rdata_ff.y};
   assign avg_entry.x = avg_x_sum[POINT_W:1];
   assign avg_entry.y = avg_y_sum[POINT_W:1];

   assign new_entry.x = quo_x_ff[POINT_W-1:0];
   assign new_entry.y = quo_y_ff[POINT_W-1:0];

   // Memory port control. During the sweep, entry k is written while entry
   // 2k+2 is read, so a write never lands on an entry still to be read.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      case (state_ff)
         ST_HALVE: begin
            mem_re    = hv_cnt_ff < LEN_W'(HISTORY_POINTS);
            mem_raddr = hv_cnt_ff[IDX_W-1:0];
            mem_we    = hv_pend_ff && hv_addr_ff[0];
            mem_waddr = hv_addr_ff >> 1;
            mem_wdata = avg_entry;
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = len_ff[IDX_W-1:0];
            mem_wdata = new_entry;
         end
         ST_EMIT: begin
            mem_re    = 1'b1;
            mem_raddr = emit_idx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stroke_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= stroke_mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         finger_down_ff   <= 1'b0;
         fire_distance_ff <= FIRE_DISTANCE_RESET;
         len_ff           <= '0;
         divisor_ff       <= COUNT_W'(1);
         sum_x_ff         <= '0;
         sum_y_ff         <= '0;
         count_ff         <= '0;
         dist_ff          <= '0;
         trig_ff          <= 1'b0;
         root_bit_ff      <= '0;
         div_cnt_ff       <= '0;
         hv_pend_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_FIRE_DISTANCE) begin
            fire_distance_ff <= csr_pwdata[DIST_W-1:0];
         end

         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (in_action == ACTION_RELEASE) begin
                     // Stroke state is kept so that a later release reports it again.
                     finger_down_ff <= 1'b0;
                     fired_ff       <= release_fired;
                     emit_idx_ff    <= '0;
                     if (release_fired && len_ff != '0) begin
                        state_ff <= ST_EMIT;
                     end else begin
                        state_ff <= ST_REPORT;
                     end
                  end else begin
                     finger_down_ff <= 1'b1;
                     len_ff         <= base_len;
                     divisor_ff     <= base_divisor;
                     dist_ff        <= base_dist;
                     sum_x_ff       <= sum_x_in;
                     sum_y_ff       <= sum_y_in;
                     count_ff       <= count_in;
                     trig_ff        <= trig_in;
                     root_v_ff      <= sq_in;
                     root_r_ff      <= '0;
                     root_bit_ff    <= ROOT_START;
                     quo_x_ff       <= DIVIDEND_W'(sum_x_in) << FRACTION_BITS;
                     quo_y_ff       <= DIVIDEND_W'(sum_y_in) << FRACTION_BITS;
                     rem_x_ff       <= '0;
                     rem_y_ff       <= '0;
                     div_cnt_ff     <= trig_in ? DIV_CNT_W'(DIVIDEND_W) : '0;
                     state_ff       <= ST_WORK;
                  end
               end
            end

            ST_WORK: begin
               if (root_bit_ff != '0) begin
                  if (root_ge) begin
                     root_v_ff <= root_v_ff - root_trial;
                     root_r_ff <= (root_r_ff >> 1) + root_bit_ff;
                  end else begin
                     root_r_ff <= root_r_ff >> 1;
                  end
                  root_bit_ff <= root_bit_ff >> 2;
               end
               if (div_cnt_ff != '0) begin
                  rem_x_ff   <= rem_x_in;
                  rem_y_ff   <= rem_y_in;
                  quo_x_ff   <= {quo_x_ff[DIVIDEND_W-2:0], div_ge_x};
                  quo_y_ff   <= {quo_y_ff[DIVIDEND_W-2:0], div_ge_y};
                  div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
               end
               if (root_bit_ff == '0 && div_cnt_ff == '0) begin
                  dist_ff    <= dist_in;
                  hv_cnt_ff  <= '0;
                  hv_pend_ff <= 1'b0;
                  if (!trig_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (history_full) begin
                     state_ff <= ST_HALVE;
                  end else begin
                     state_ff <= ST_WRITE;
                  end
               end
            end

            ST_HALVE: begin
               // Even entries wait in the hold register for their odd partner.
               hv_pend_ff <= mem_re;
               hv_addr_ff <= mem_raddr;
               if (mem_re) begin
                  hv_cnt_ff <= hv_cnt_ff + LEN_W'(1);
               end
               if (hv_pend_ff && !hv_addr_ff[0]) begin
                  hv_hold_ff <= mem_rdata_ff;
               end
               if (!mem_re && !hv_pend_ff) begin
                  len_ff     <= LEN_W'(HISTORY_POINTS / 2);
                  divisor_ff <= divisor_in;
                  state_ff   <= ST_WRITE;
               end
            end

            ST_WRITE: begin
               len_ff   <= len_ff + LEN_W'(1);
               sum_x_ff <= '0;
               sum_y_ff <= '0;
               count_ff <= '0;
               state_ff <= ST_IDLE;
            end

            ST_REPORT: begin
               if (rsp_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_fired_ff       <= fired_ff;
                  rsp_point_valid_ff <= 1'b0;
                  rsp_x_ff           <= '0;
                  rsp_y_ff           <= '0;
                  rsp_index_ff       <= '0;
                  rsp_total_ff       <= TOTAL_OUT_W'(len_ff);
                  rsp_last_ff        <= 1'b1;
                  state_ff           <= ST_IDLE;
               end
            end

            ST_EMIT: begin
               state_ff <= ST_LOAD;
            end

            ST_LOAD: begin
               // The read data register holds until the next read, so the
               // entry waits here for the output register to free up.
               if (rsp_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_fired_ff       <= 1'b1;
                  rsp_point_valid_ff <= 1'b1;
                  rsp_x_ff           <= mem_rdata_ff.x[FRACTION_BITS +: COORD_W];
                  rsp_y_ff           <= mem_rdata_ff.y[FRACTION_BITS +: COORD_W];
                  rsp_index_ff       <= INDEX_OUT_W'(emit_idx_ff);
                  rsp_total_ff       <= TOTAL_OUT_W'(len_ff);
                  rsp_last_ff        <= emit_last;
                  if (emit_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     emit_idx_ff <= emit_idx_ff + IDX_W'(1);
                     state_ff    <= ST_EMIT;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_point_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_total_ff, rsp_index_ff,
                        rsp_y_ff, rsp_x_ff, rsp_fired_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_FIRE_DISTANCE) ?
                       CSR_DATA_W'(fire_distance_ff) : '0;

   `TSD_ASSERT_ALWAYS(a_len_bounded, len_ff <= LEN_W'(HISTORY_POINTS),
                      "stroke length beyond history depth")
   `TSD_ASSERT_ALWAYS(a_divisor_odd, divisor_ff[0], "group divisor lost its odd step")
   `TSD_ASSERT_IMPL(a_idle_count, state_ff == ST_IDLE, count_ff < divisor_ff,
                    "open group reached the divisor while idle")
   `TSD_ASSERT_NEXT(a_press_down, req_xfer && (in_action == ACTION_PRESS),
                    finger_down_ff && (state_ff == ST_WORK),
                    "pressed sample did not start a stroke update")

endmodule

`default_nettype wire
